// File: hw/rtl/node_frequency_rank_defines.svh
// Assertion macros shared by the node frequency rank RTL
`ifndef NODE_FREQUENCY_RANK_DEFINES_SVH
`define NODE_FREQUENCY_RANK_DEFINES_SVH

// same-cycle implication
`define NFR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nfr implication check failed");

// next-cycle implication
`define NFR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nfr next-cycle check failed");

`endif

// File: hw/rtl/nfr_pkg.sv
// Package: sizes, action codes and sequencer states of node_frequency_rank
package nfr_pkg;
   localparam int MAX_NODES  = 1024;
   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int IDX_BITS   = NODE_BITS + 1;
   localparam int COUNT_BITS = 32;
   localparam int CSR_BITS   = 11;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [IDX_BITS-1:0]   N_MAX     = IDX_BITS'(MAX_NODES);

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_COUNT = 2'd1,
      ACT_RANK  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLR,
      S_CNT_RD,
      S_RRD,
      S_RCNT,
      S_RK_LD,
      S_RK_LAT,
      S_RK_SCAN,
      S_RK_WR
   } state_type;
endpackage

// File: hw/rtl/nfr_ram.sv
// Generic single-write, single-read RAM with registered read data
module nfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/node_frequency_rank.sv
// Top level: per-node access counter with ranking by descending count
//
// Command block: an item is taken when start is high and busy is low; each item gives exactly one
// result, shown for a single cycle with rsp_valid, and the receiver cannot stall it. After reset
// the count table is swept to zero with busy high. A ranking build uses one comparator against
// one count RAM read port: each node i is placed by counting the nodes that rank before it. Ties
// go to the lower node id.
module node_frequency_rank
   import nfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [NODE_BITS-1:0]  req_node_id,
   input  logic [NODE_BITS-1:0]  req_rank_position,
   input  logic                  csr_wr_en,
   input  logic [CSR_BITS-1:0]   csr_wr_data,
   output logic                  rsp_valid,
   output logic [NODE_BITS-1:0]  rsp_ranked_node,
   output logic [COUNT_BITS-1:0] rsp_node_count,
   output logic                  rsp_status
);
`include "node_frequency_rank_defines.svh"

   state_type state_ff, state_in;
   logic [CSR_BITS-1:0]   csr_ff;
   logic [IDX_BITS-1:0]   i_ff, i_in, j_ff, j_in, pj_ff, pj_in, pos_ff, pos_in;
   logic                  pend_ff, pend_in;
   logic [COUNT_BITS-1:0] ci_ff, ci_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic                  rv_ff, rv_in, rs_ff, rs_in;
   logic [NODE_BITS-1:0]  rn_ff, rn_in;
   logic [COUNT_BITS-1:0] rc_ff, rc_in;

   logic [IDX_BITS-1:0]   n_eff, i_nxt;
   logic                  accept, pj_ahead;
   action_type            act;

   logic                  cnt_we, rnk_we;
   logic [NODE_BITS-1:0]  cnt_wa, cnt_ra, rnk_wa, rnk_ra;
   logic [COUNT_BITS-1:0] cnt_wd, cnt_rd, cnt_inc;
   logic [NODE_BITS-1:0]  rnk_wd, rnk_rd;

   nfr_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(cnt_ra), .rd_data(cnt_rd)
   );

   nfr_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_rnk_ram (
      .clock(clock), .wr_en(rnk_we), .wr_addr(rnk_wa), .wr_data(rnk_wd),
      .rd_addr(rnk_ra), .rd_data(rnk_rd)
   );

   always_comb begin
      if (csr_ff == '0) begin
         n_eff = IDX_BITS'(1);
      end else if (IDX_BITS'(csr_ff) > N_MAX) begin
         n_eff = N_MAX;
      end else begin
         n_eff = IDX_BITS'(csr_ff);
      end
   end

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign act     = action_type'(req_action);
   assign i_nxt   = i_ff + IDX_BITS'(1);
   assign cnt_inc = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
   // shared compare: node pj ranks before node i
   assign pj_ahead = (cnt_rd > ci_ff) || ((cnt_rd == ci_ff) && (pj_ff < i_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT, S_CLR: begin
            if (j_ff == N_MAX - IDX_BITS'(1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (act)
                  ACT_CLEAR: state_in = S_CLR;
                  ACT_COUNT: state_in = ({1'b0, req_node_id} < n_eff) ? S_CNT_RD : S_IDLE;
                  ACT_RANK:  state_in = S_RK_LD;
                  ACT_READ:  state_in = ({1'b0, req_rank_position} < n_eff) ? S_RRD : S_IDLE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CNT_RD:  state_in = S_IDLE;
         S_RRD:     state_in = S_RCNT;
         S_RCNT:    state_in = S_IDLE;
         S_RK_LD:   state_in = S_RK_LAT;
         S_RK_LAT:  state_in = S_RK_SCAN;
         S_RK_SCAN: begin
            if (j_ff == n_eff && !pend_ff) state_in = S_RK_WR;
         end
         S_RK_WR:   state_in = (i_nxt == n_eff) ? S_IDLE : S_RK_LD;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      pj_in   = pj_ff;
      pos_in  = pos_ff;
      pend_in = 1'b0;
      ci_in   = ci_ff;
      node_in = node_ff;
      rv_in   = 1'b0;
      rs_in   = 1'b0;
      rn_in   = '0;
      rc_in   = '0;
      cnt_we  = 1'b0;
      cnt_wa  = node_ff;
      cnt_wd  = '0;
      cnt_ra  = node_ff;
      rnk_we  = 1'b0;
      rnk_wa  = pos_ff[NODE_BITS-1:0];
      rnk_wd  = i_ff[NODE_BITS-1:0];
      rnk_ra  = req_rank_position;
      unique case (state_ff)
         S_INIT, S_CLR: begin
            cnt_we = 1'b1;
            cnt_wa = j_ff[NODE_BITS-1:0];
            j_in   = j_ff + IDX_BITS'(1);
            if (j_ff == N_MAX - IDX_BITS'(1)) begin
               rv_in = (state_ff == S_CLR);
            end
         end
         S_IDLE: begin
            node_in = req_node_id;
            cnt_ra  = req_node_id;
            j_in    = '0;
            i_in    = '0;
            if (accept) begin
               if (act == ACT_COUNT && {1'b0, req_node_id} >= n_eff) begin
                  rv_in = 1'b1;
                  rs_in = 1'b1;
               end
               if (act == ACT_READ && {1'b0, req_rank_position} >= n_eff) begin
                  rv_in = 1'b1;
                  rs_in = 1'b1;
               end
            end
         end
         S_CNT_RD: begin
            cnt_we = 1'b1;
            cnt_wd = cnt_inc;
            rv_in  = 1'b1;
            rc_in  = cnt_inc;
         end
         S_RRD: begin
            cnt_ra  = rnk_rd;
            node_in = rnk_rd;
         end
         S_RCNT: begin
            rv_in = 1'b1;
            rn_in = node_ff;
            rc_in = cnt_rd;
         end
         S_RK_LD: begin
            cnt_ra = i_ff[NODE_BITS-1:0];
            j_in   = '0;
            pos_in = '0;
         end
         S_RK_LAT: begin
            ci_in = cnt_rd;
         end
         S_RK_SCAN: begin
            cnt_ra = j_ff[NODE_BITS-1:0];
            if (j_ff != n_eff) begin
               pend_in = 1'b1;
               pj_in   = j_ff;
               j_in    = j_ff + IDX_BITS'(1);
            end
            if (pend_ff && pj_ahead) pos_in = pos_ff + IDX_BITS'(1);
         end
         S_RK_WR: begin
            rnk_we = 1'b1;
            i_in   = i_nxt;
            rv_in  = (i_nxt == n_eff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         csr_ff   <= CSR_BITS'(MAX_NODES);
         j_ff     <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) csr_ff <= csr_wr_data;
         j_ff     <= j_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
      i_ff    <= i_in;
      pj_ff   <= pj_in;
      pos_ff  <= pos_in;
      ci_ff   <= ci_in;
      node_ff <= node_in;
      rs_ff   <= rs_in;
      rn_ff   <= rn_in;
      rc_ff   <= rc_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rs_ff;
   assign rsp_ranked_node = rn_ff;
   assign rsp_node_count  = rc_ff;

   `NFR_ASSERT_IMP(a_rsp_when_idle, rsp_valid, !busy)
   `NFR_ASSERT_NXT(a_accept_acts, accept, busy || rsp_valid)
   `NFR_ASSERT_IMP(a_rank_slot_in_range, state_ff == S_RK_WR, pos_ff < n_eff)
   `NFR_ASSERT_IMP(a_err_only_fast, rsp_valid && rsp_status, rsp_node_count == '0)
endmodule

// File: tb/node_frequency_rank_tb.sv
// Testbench for node_frequency_rank: directed and random command streams checked against a model
`timescale 1ns / 100ps

module node_frequency_rank_tb
   import nfr_pkg::*;
();

   typedef struct packed {
      logic [NODE_BITS-1:0]  ranked_node;
      logic [COUNT_BITS-1:0] node_count;
      logic                  status;
   } answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_action = 2'd0;
   logic [NODE_BITS-1:0]  req_node_id = '0;
   logic [NODE_BITS-1:0]  req_rank_position = '0;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_BITS-1:0]   csr_wr_data = '0;
   logic                  rsp_valid;
   logic [NODE_BITS-1:0]  rsp_ranked_node;
   logic [COUNT_BITS-1:0] rsp_node_count;
   logic                  rsp_status;

   // model state
   logic [COUNT_BITS-1:0] hit_count [MAX_NODES];
   logic [NODE_BITS-1:0]  rank_slot [MAX_NODES];
   int unsigned           nodes_cfg = MAX_NODES;
   int unsigned           ranked_span = 0;   // slots below this hold a ranked node

   answer_type answer_q [$];
   int      mismatches = 0;
   int      words_sent = 0;
   int      answers_seen = 0;
   int      rank_builds = 0;
   int      gap_pct = 0;

   always #2 clock = ~clock;

   node_frequency_rank u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_node_id(req_node_id),
      .req_rank_position(req_rank_position),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_ranked_node(rsp_ranked_node),
      .rsp_node_count(rsp_node_count), .rsp_status(rsp_status)
   );

   function automatic int unsigned live_nodes();
      if (nodes_cfg == 0) return 1;
      if (nodes_cfg > MAX_NODES) return MAX_NODES;
      return nodes_cfg;
   endfunction

   function automatic bit outranks(int unsigned a, int unsigned b);
      if (hit_count[a] != hit_count[b]) return hit_count[a] > hit_count[b];
      return a < b;
   endfunction

   function automatic answer_type apply_word(action_type act, int unsigned node, int unsigned pos);
      answer_type  ans;
      int unsigned n;
      int unsigned place;
      n = live_nodes();
      ans = '0;
      case (act)
         ACT_CLEAR: begin
            for (int i = 0; i < MAX_NODES; i++) hit_count[i] = '0;
         end
         ACT_COUNT: begin
            if (node >= n) ans.status = 1'b1;
            else begin
               if (hit_count[node] != COUNT_MAX) hit_count[node] = hit_count[node] + 1;
               ans.node_count = hit_count[node];
            end
         end
         ACT_RANK: begin
            // each node lands at the number of nodes that outrank it
            for (int i = 0; i < n; i++) begin
               place = 0;
               for (int j = 0; j < n; j++) if (outranks(j, i)) place++;
               rank_slot[place] = NODE_BITS'(i);
            end
            if (n > ranked_span) ranked_span = n;
         end
         default: begin
            if (pos >= n) ans.status = 1'b1;
            else begin
               ans.ranked_node = rank_slot[pos];
               ans.node_count  = hit_count[rank_slot[pos]];
            end
         end
      endcase
      return ans;
   endfunction

   // called at a rising edge; returns at the edge that accepted the word, or after a random gap with start low
   task automatic send_word(action_type act, int unsigned node, int unsigned pos);
      start             <= 1'b1;
      req_action        <= act;
      req_node_id       <= NODE_BITS'(node);
      req_rank_position <= NODE_BITS'(pos);
      @(posedge clock);
      while (busy) @(posedge clock);
      answer_q.push_back(apply_word(act, node, pos));
      words_sent++;
      if (act == ACT_RANK) rank_builds++;
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (answer_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_nodes(int unsigned value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CSR_BITS'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nodes_cfg = value;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
         end else begin
            automatic answer_type exp = answer_q.pop_front();
            if (rsp_ranked_node !== exp.ranked_node || rsp_node_count !== exp.node_count ||
                rsp_status !== exp.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp node %0d count %0d st %0b, got %0d %0d %0b",
                           $realtime, exp.ranked_node, exp.node_count, exp.status,
                           rsp_ranked_node, rsp_node_count, rsp_status);
            end
         end
      end
   end

   task automatic test_directed();
      gap_pct = 0;
      send_word(ACT_COUNT, 0, 0);
      send_word(ACT_COUNT, 1023, 0);
      send_word(ACT_COUNT, 1023, 1023);
      write_nodes(5);
      send_word(ACT_READ, 0, 1023);      // nothing ranked yet: only out-of-range reads
      send_word(ACT_COUNT, 3, 0);
      send_word(ACT_COUNT, 3, 0);
      send_word(ACT_COUNT, 1, 0);
      send_word(ACT_COUNT, 4, 0);        // tie between 0, 1 and 4
      send_word(ACT_COUNT, 5, 0);        // id out of range
      send_word(ACT_RANK, 0, 0);
      for (int p = 0; p < 5; p++) send_word(ACT_READ, 0, p);
      send_word(ACT_READ, 0, 5);
      send_word(ACT_CLEAR, 0, 0);
      send_word(ACT_READ, 0, 0);
      write_nodes(0);                    // acts as one node
      send_word(ACT_RANK, 0, 0);
      send_word(ACT_READ, 0, 0);
      send_word(ACT_COUNT, 1, 0);
      write_nodes(2047);                 // clipped to the maximum
      send_word(ACT_COUNT, 1023, 0);
      send_word(ACT_READ, 0, 3);
   endtask

   task automatic test_random(int pct, int segments);
      int unsigned n;
      int unsigned roll;
      int unsigned lim;
      gap_pct = pct;
      for (int s = 0; s < segments; s++) begin
         case ($urandom_range(9))
            0: write_nodes(0);
            1: write_nodes(1);
            2: write_nodes(MAX_NODES);
            3: write_nodes(2047);
            default: write_nodes($urandom_range(48, 2));
         endcase
         n = live_nodes();
         if (s == 2) drain();
         for (int k = 0; k < 95; k++) begin
            roll = $urandom_range(99);
            lim = (ranked_span < n) ? ranked_span : n;
            if (roll < 3) send_word(ACT_CLEAR, 0, 0);
            else if (roll < 11 && n <= 64) send_word(ACT_RANK, $urandom, $urandom);
            else if (roll < 35 && (lim > 0 || n < MAX_NODES)) begin
               if (lim > 0 && (n >= MAX_NODES || $urandom_range(9) != 0))
                  send_word(ACT_READ, $urandom, $urandom_range(lim - 1));
               else
                  send_word(ACT_READ, $urandom, $urandom_range(MAX_NODES - 1, n));
            end else if ($urandom_range(9) == 0)
               send_word(ACT_COUNT, $urandom_range(MAX_NODES - 1), $urandom);
            else
               send_word(ACT_COUNT, $urandom_range(n - 1), $urandom);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_NODES; i++) begin
         hit_count[i] = '0;
         rank_slot[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(33, 6);
      test_random(51, 6);
      test_random(0, 6);
      drain();
      repeat (20) @(posedge clock);
      $display("%0d words sent, %0d results checked, %0d rankings built",
               words_sent, answers_seen, rank_builds);
      $display("node counts 0..2047 incl. clipped values, sender gaps on and off");
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, answer_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout, %0d results outstanding", answer_q.size());
      $display("Regression FAIL");
      $finish;
   end
endmodule
